### sv/ubxfr_pkg.sv
package ubxfr_pkg;

	// Sync pair that opens every frame
	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	// Message codes of interest
	localparam logic [7:0] CLASS_NAV   = 8'h01;
	localparam logic [7:0] ID_STATUS   = 8'h03;
	localparam logic [7:0] ID_SVINFO   = 8'h30;

	// Fix types that count as a usable fix
	localparam logic [7:0] FIX_2D      = 8'h02;
	localparam logic [7:0] FIX_3D      = 8'h03;

	// Channel block layout inside the satellite info payload
	localparam logic [3:0] CHAN_LAST_PHASE = 4'd11;
	localparam logic [3:0] QUAL_PHASE      = 4'd3;

	// Header byte positions after sync, and payload offsets
	localparam int HDR_BYTES     = 4;
	localparam int FIX_OFFSET    = 4;
	localparam int CHAN_OFFSET   = 8;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic       in_frame;
		logic       has_fix;
		logic [7:0] sat_count;
		logic       status_event;
		logic       svinfo_event;
		logic       checksum_error;
		logic       length_error;
	} ubxfr_result_t;

endpackage

### sv/ubxfr_parser.sv
module ubxfr_parser
	import ubxfr_pkg::*;
#(
	parameter int FRAME_BYTES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    min_quality,
	output ubxfr_result_t result
);

	localparam int PW = $clog2(FRAME_BYTES);

	localparam logic [PW-1:0] POS_CLASS = PW'(0);
	localparam logic [PW-1:0] POS_ID    = PW'(1);
	localparam logic [PW-1:0] POS_LEN_L = PW'(2);
	localparam logic [PW-1:0] POS_HDR   = PW'(HDR_BYTES);
	localparam logic [PW-1:0] POS_FIX   = PW'(HDR_BYTES + FIX_OFFSET);
	localparam logic [PW-1:0] POS_CHAN  = PW'(HDR_BYTES + CHAN_OFFSET);
	localparam logic [15:0]   LEN_MAX   = 16'(FRAME_BYTES - 6);

	logic          recv_q,    recv_n;
	logic [7:0]    prev_q,    prev_n;
	logic [PW-1:0] pos_q,     pos_n;
	logic [7:0]    sum_a_q,   sum_a_n;
	logic [7:0]    sum_b_q,   sum_b_n;
	logic [7:0]    class_q,   class_n;
	logic [7:0]    id_q,      id_n;
	logic [15:0]   len_q,     len_n;
	logic [7:0]    check_a_q, check_a_n;
	logic [7:0]    field4_q,  field4_n;
	logic [7:0]    good_q,    good_n;
	logic          fix_q,     fix_n;
	logic [7:0]    sats_q,    sats_n;
	logic [3:0]    phase_q,   phase_n;
	logic [7:0]    chidx_q,   chidx_n;

	logic [PW-1:0] end_pos;
	logic [15:0]   len_full;
	logic          ev_status, ev_svinfo, ev_cks, ev_len;

	assign end_pos  = len_q[PW-1:0] + POS_HDR;
	assign len_full = {rx_byte, len_q[7:0]};

	// Work out the next state for the byte in hand
	always_comb begin
		recv_n    = recv_q;
		pos_n     = pos_q;
		sum_a_n   = sum_a_q;
		sum_b_n   = sum_b_q;
		class_n   = class_q;
		id_n      = id_q;
		len_n     = len_q;
		check_a_n = check_a_q;
		field4_n  = field4_q;
		good_n    = good_q;
		fix_n     = fix_q;
		sats_n    = sats_q;
		phase_n   = phase_q;
		chidx_n   = chidx_q;
		ev_status = 1'b0;
		ev_svinfo = 1'b0;
		ev_cks    = 1'b0;
		ev_len    = 1'b0;
		prev_n    = rx_byte;

		if (!recv_q) begin
			// Hunt for the sync pair and clear the frame state
			if (prev_q == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
				recv_n    = 1'b1;
				pos_n     = '0;
				sum_a_n   = '0;
				sum_b_n   = '0;
				class_n   = '0;
				id_n      = '0;
				len_n     = '0;
				check_a_n = '0;
				field4_n  = '0;
				good_n    = '0;
				phase_n   = '0;
				chidx_n   = '0;
			end
		end else begin
			if (pos_q < POS_HDR) begin
				// Header: class, id, length
				sum_a_n = sum_a_q + rx_byte;
				sum_b_n = sum_b_q + sum_a_n;
				if (pos_q == POS_CLASS) begin
					class_n = rx_byte;
				end else if (pos_q == POS_ID) begin
					id_n = rx_byte;
				end else if (pos_q == POS_LEN_L) begin
					len_n = {8'd0, rx_byte};
				end else begin
					len_n = len_full;
					if (len_full > LEN_MAX) begin
						ev_len = 1'b1;
						recv_n = 1'b0;
					end
				end
			end else if (pos_q < end_pos) begin
				// Payload: pick out fix type and channel qualities
				sum_a_n = sum_a_q + rx_byte;
				sum_b_n = sum_b_q + sum_a_n;
				if (pos_q == POS_FIX) begin
					field4_n = rx_byte;
				end
				if (pos_q >= POS_CHAN) begin
					if (phase_q == QUAL_PHASE && chidx_q < field4_q &&
					    rx_byte >= min_quality && good_q != COUNT_MAX) begin
						good_n = good_q + 8'd1;
					end
					if (phase_q == CHAN_LAST_PHASE) begin
						phase_n = '0;
						if (chidx_q != COUNT_MAX) begin
							chidx_n = chidx_q + 8'd1;
						end
					end else begin
						phase_n = phase_q + 4'd1;
					end
				end
			end else if (pos_q == end_pos) begin
				check_a_n = rx_byte;
			end else begin
				// Second check byte: judge the frame and commit
				if (sum_a_q == check_a_q && sum_b_q == rx_byte) begin
					if (class_q == CLASS_NAV && id_q == ID_STATUS) begin
						fix_n     = (field4_q == FIX_2D || field4_q == FIX_3D);
						ev_status = 1'b1;
					end else if (class_q == CLASS_NAV && id_q == ID_SVINFO) begin
						sats_n    = good_q;
						ev_svinfo = 1'b1;
					end
				end else begin
					ev_cks = 1'b1;
				end
				recv_n = 1'b0;
			end
			pos_n = pos_q + PW'(1);
		end
	end

	// Advance the frame state once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q    <= 1'b0;
			prev_q    <= '0;
			pos_q     <= '0;
			sum_a_q   <= '0;
			sum_b_q   <= '0;
			class_q   <= '0;
			id_q      <= '0;
			len_q     <= '0;
			check_a_q <= '0;
			field4_q  <= '0;
			good_q    <= '0;
			fix_q     <= 1'b0;
			sats_q    <= '0;
			phase_q   <= '0;
			chidx_q   <= '0;
		end else if (step) begin
			recv_q    <= recv_n;
			prev_q    <= prev_n;
			pos_q     <= pos_n;
			sum_a_q   <= sum_a_n;
			sum_b_q   <= sum_b_n;
			class_q   <= class_n;
			id_q      <= id_n;
			len_q     <= len_n;
			check_a_q <= check_a_n;
			field4_q  <= field4_n;
			good_q    <= good_n;
			fix_q     <= fix_n;
			sats_q    <= sats_n;
			phase_q   <= phase_n;
			chidx_q   <= chidx_n;
		end
	end

	// Result for this byte
	assign result.in_frame       = recv_n;
	assign result.has_fix        = fix_n;
	assign result.sat_count      = sats_n;
	assign result.status_event   = ev_status;
	assign result.svinfo_event   = ev_svinfo;
	assign result.checksum_error = ev_cks;
	assign result.length_error   = ev_len;

endmodule

### sv/ubx_frame_receiver_top.sv
// Byte-serial receiver for framed binary navigation messages.
// Input channel: in_valid / in_ready with rx_byte, one received byte per transfer.
// Output channel: out_valid / out_ready with one result per input byte:
// in_frame, has_fix, sat_count and the single-byte event flags
// status_event, svinfo_event, checksum_error, length_error.
// Configuration channel: cfg_valid / cfg_ready with min_quality, the least
// channel quality counted as a usable satellite; cfg_ready is always high.
// Write it only while no byte is in flight.
// Each byte goes through the input register and then the result register;
// out_valid rises when the result register loads on advance.
// Throughput: one byte per cycle while out_ready is high; the per-byte parse
// logic between the input and result registers touches each byte once.
// When out_ready is low the result register holds, the input register still
// takes one byte, then in_ready drops until the result is taken.
// Reset clears the valid bits of both registers, sets min_quality to 2 and
// returns the parser to hunting for sync with the fix flag and satellite count at zero.
module ubx_frame_receiver_top
	import ubxfr_pkg::*;
#(
	parameter int FRAME_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       in_frame,
	output logic       has_fix,
	output logic [7:0] sat_count,
	output logic       status_event,
	output logic       svinfo_event,
	output logic       checksum_error,
	output logic       length_error,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] min_quality
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          valid_s2;
	ubxfr_result_t res_s2;
	ubxfr_result_t res_next;
	logic [7:0]    min_quality_q;
	logic          advance;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_quality_q <= 8'd2;
		end else if (cfg_valid) begin
			min_quality_q <= min_quality;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	ubxfr_parser #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (byte_s1),
		.min_quality(min_quality_q),
		.result     (res_next)
	);

	// Result register: load on advance, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid      = valid_s2;
	assign in_frame       = res_s2.in_frame;
	assign has_fix        = res_s2.has_fix;
	assign sat_count      = res_s2.sat_count;
	assign status_event   = res_s2.status_event;
	assign svinfo_event   = res_s2.svinfo_event;
	assign checksum_error = res_s2.checksum_error;
	assign length_error   = res_s2.length_error;

endmodule
